[hdl/pdc_pkg.sv]
package pdc_pkg;

    // sizes fixed by the request fields
    localparam int STORE_BYTES_DEF = 64;
    localparam int DUR_W           = 24;
    localparam int CT_W            = 16;
    localparam int QUO_W           = DUR_W + 1;
    localparam int ADDR_IN_W       = 6;
    localparam int COUNT_W         = 10;

    localparam logic [CT_W-1:0] CHIP_TIME_RESET = 16'd100;

    // request modes
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FILL,
        ST_REPLY
    } seq_state_t;

    // commands from the sequencer to the chip store
    typedef struct packed {
        logic                 clear;
        logic                 load;
        logic                 value;
        logic [QUO_W-1:0]     count;
        logic                 rd_req;
        logic [ADDR_IN_W-1:0] rd_addr;
    } store_cmd_t;

    // status back from the chip store
    typedef struct packed {
        logic filling;
        logic full;
    } store_stat_t;

endpackage

[hdl/pdc_div.sv]
module pdc_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [pdc_pkg::QUO_W-1:0]    dividend,
    input  logic [pdc_pkg::CT_W-1:0]     divisor,
    output logic                         done,
    output logic [pdc_pkg::QUO_W-1:0]    quotient
);
    import pdc_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic              running_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CT_W-1:0]   rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CT_W:0]     shifted;
    logic [CT_W:0]     diff;
    logic              fits;

    // one restoring step: shift in the next dividend bit and try the subtract
    // a zero divisor always fits, giving an all-ones quotient
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                running_reg <= 1'b1;
                step_reg    <= '0;
            end
            else if (running_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (running_reg)
        begin
            rem_reg <= fits ? diff[CT_W-1:0] : shifted[CT_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/pdc_chip_store.sv]
module pdc_chip_store
#(
    parameter  int STORE_BYTES = pdc_pkg::STORE_BYTES_DEF,
    localparam int CAP         = STORE_BYTES * 8,
    localparam int IDX_W       = $clog2(CAP + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdc_pkg::store_cmd_t  cmd,
    output pdc_pkg::store_stat_t stat,
    output logic [IDX_W-1:0]     chip_index,
    output logic [7:0]           rd_data
);
    import pdc_pkg::*;

    localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CMP_W  = 13;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_MEM,
        RD_PART
    } rd_sel_t;

    logic [7:0]       mem [STORE_BYTES];

    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] remain_reg;
    logic [7:0]       cur_byte_reg;
    logic             value_reg;
    rd_sel_t          rd_sel_reg;
    logic [7:0]       mem_q_reg;
    logic [7:0]       part_q_reg;

    logic [2:0]       bit_pos;
    logic [3:0]       space;
    logic [3:0]       n_chips;
    logic [3:0]       end_pos;
    logic [7:0]       mask;
    logic [7:0]       new_byte;
    logic             byte_done;
    logic [IDX_W-1:0] room;
    logic [IDX_W-1:0] remain_load;
    logic [ADDR_W-1:0] wr_addr;
    logic [CMP_W-1:0] rd_addr_ext;
    logic [CMP_W-1:0] full_bytes;

    // chips that fit into the current byte this cycle
    assign bit_pos   = index_reg[2:0];
    assign space     = 4'd8 - {1'b0, bit_pos};
    assign n_chips   = (remain_reg < IDX_W'(space)) ? remain_reg[3:0] : space;
    assign end_pos   = {1'b0, bit_pos} + n_chips;
    assign mask      = (8'hFF >> bit_pos) & ~(8'hFF >> end_pos);
    assign new_byte  = value_reg ? (cur_byte_reg | mask) : cur_byte_reg;
    assign byte_done = (remain_reg != '0) && (end_pos == 4'd8);
    assign wr_addr   = index_reg[ADDR_W+2:3];

    // clamp the pulse length to the room left in the store
    assign room        = IDX_W'(CAP) - index_reg;
    assign remain_load = (cmd.count > QUO_W'(room)) ? room : cmd.count[IDX_W-1:0];

    // fill and clear control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= '0;
            remain_reg   <= '0;
            cur_byte_reg <= '0;
        end
        else if (cmd.clear)
        begin
            index_reg    <= '0;
            remain_reg   <= '0;
            cur_byte_reg <= '0;
        end
        else if (cmd.load)
        begin
            remain_reg <= remain_load;
        end
        else if (remain_reg != '0)
        begin
            index_reg    <= index_reg + IDX_W'(n_chips);
            remain_reg   <= remain_reg - IDX_W'(n_chips);
            cur_byte_reg <= byte_done ? 8'h00 : new_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= cmd.value;
        end
    end

    // completed bytes go to memory, bytes past the fill point read as zero
    always_ff @(posedge clk)
    begin
        if (byte_done)
        begin
            mem[wr_addr] <= new_byte;
        end
    end

    // read port
    assign rd_addr_ext = CMP_W'(cmd.rd_addr);
    assign full_bytes  = CMP_W'(index_reg >> 3);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_req)
        begin
            mem_q_reg  <= mem[rd_addr_ext[ADDR_W-1:0]];
            part_q_reg <= cur_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_sel_reg <= RD_ZERO;
        end
        else if (cmd.rd_req)
        begin
            if (rd_addr_ext >= CMP_W'(STORE_BYTES))
                rd_sel_reg <= RD_ZERO;
            else if (rd_addr_ext < full_bytes)
                rd_sel_reg <= RD_MEM;
            else if (rd_addr_ext == full_bytes)
                rd_sel_reg <= RD_PART;
            else
                rd_sel_reg <= RD_ZERO;
        end
    end

    always_comb
    begin
        case (rd_sel_reg)
            RD_MEM:  rd_data = mem_q_reg;
            RD_PART: rd_data = part_q_reg;
            default: rd_data = 8'h00;
        endcase
    end

    assign stat.filling = (remain_reg != '0);
    assign stat.full    = (index_reg >= IDX_W'(CAP));
    assign chip_index   = index_reg;

endmodule

[hdl/pulse_durations_to_chip_bits.sv]
// channel      ports                                   handshake
// -----------  --------------------------------------  ---------------------------
// request      mode, duration, byte_address            start high while busy low
// result       chip_count, read_data, store_full       done high for one cycle
// chip time    chip_time                               chip_time_we high
//
// start, read and unused-mode requests: done in the cycle right after the accepting edge.
// pulse: the restoring divider forms the chip count, then the count is clamped and loaded,
// then the store is filled one byte at a time (about chips / 8 + 1 bytes touched), then
// the fill end is seen, then the done cycle follows.
// busy stays high through the done cycle, so the next request is taken in the cycle after it.
// reset clears the chip count, parity and chip time (to 100); the byte memory
// needs no clearing since bytes past the fill point read as zero.
// the receiver cannot stall: the result is shown for its one done cycle only.
module pulse_durations_to_chip_bits
#(
    parameter int STORE_BYTES = pdc_pkg::STORE_BYTES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [pdc_pkg::DUR_W-1:0]         duration,
    input  logic [pdc_pkg::ADDR_IN_W-1:0]     byte_address,
    input  logic                              chip_time_we,
    input  logic [pdc_pkg::CT_W-1:0]          chip_time,
    output logic                              done,
    output logic [pdc_pkg::COUNT_W-1:0]       chip_count,
    output logic [7:0]                        read_data,
    output logic                              store_full
);
    import pdc_pkg::*;

    localparam int CAP   = STORE_BYTES * 8;
    localparam int IDX_W = $clog2(CAP + 1);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic             space_reg;
    logic             space_next;
    logic             is_read_reg;
    logic             is_read_next;
    logic [CT_W-1:0]  chip_time_reg;

    store_cmd_t       cmd;
    store_stat_t      stat;
    logic [IDX_W-1:0] chip_index;
    logic [7:0]       rd_data;
    logic             div_go;
    logic             div_done;
    logic [QUO_W-1:0] quotient;
    logic [QUO_W-1:0] dividend;
    logic [31:0]      count_wide;

    // chip time register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chip_time_reg <= CHIP_TIME_RESET;
        else if (chip_time_we)
            chip_time_reg <= chip_time;
    end

    // round to nearest by adding half a chip before dividing
    assign dividend = QUO_W'(duration) + QUO_W'(chip_time_reg >> 1);

    pdc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (dividend),
        .divisor  (chip_time_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    pdc_chip_store #(.STORE_BYTES(STORE_BYTES)) u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .chip_index (chip_index),
        .rd_data    (rd_data)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            space_reg   <= 1'b0;
            is_read_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            space_reg   <= space_next;
            is_read_reg <= is_read_next;
        end
    end

    // sequencer next state and commands
    always_comb
    begin
        state_next   = state_reg;
        space_next   = space_reg;
        is_read_next = is_read_reg;
        div_go       = 1'b0;
        cmd          = '0;
        cmd.rd_addr  = byte_address;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    is_read_next = 1'b0;
                    state_next   = ST_REPLY;
                    case (mode_t'(mode))
                        MODE_START:
                        begin
                            cmd.clear  = 1'b1;
                            space_next = 1'b0;
                        end
                        MODE_PULSE:
                        begin
                            div_go     = 1'b1;
                            state_next = ST_DIVIDE;
                        end
                        MODE_READ:
                        begin
                            cmd.rd_req   = 1'b1;
                            is_read_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    // a mark of zero chips still takes one chip
                    cmd.load  = 1'b1;
                    cmd.value = ~space_reg;
                    if (!space_reg && (quotient == '0))
                        cmd.count = QUO_W'(1);
                    else
                        cmd.count = quotient;
                    space_next = ~space_reg;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (!stat.filling)
                    state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result
    assign count_wide = 32'(chip_index);
    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_REPLY);
    assign chip_count = count_wide[COUNT_W-1:0];
    assign read_data  = is_read_reg ? rd_data : 8'h00;
    assign store_full = stat.full;

endmodule

[sim/pulse_durations_to_chip_bits_tb.sv]
`timescale 1ns / 100ps

module pulse_durations_to_chip_bits_tb;

    import pdc_pkg::*;

    localparam int CHIP_CAPACITY = STORE_BYTES_DEF * 8;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int CT_PHASES     = 8;

    // one reported result
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         data;
        logic               full;
    } chip_report_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // directed stimulus row: a request, or a chip time write
    typedef struct packed {
        row_kind_t              kind;
        mode_t                  mode;
        logic [DUR_W-1:0]       dur;
        logic [ADDR_IN_W-1:0]   addr;
        logic [CT_W-1:0]        ct;
        logic                   fixed;
        chip_report_t           want;
    } stim_row_t;

    localparam chip_report_t EMPTY_REPORT = '{10'd0, 8'h00, 1'b0};
    localparam chip_report_t FULL_REPORT  = '{10'd512, 8'h00, 1'b1};
    localparam chip_report_t ONE_CHIP     = '{10'd1, 8'h00, 1'b0};
    localparam chip_report_t BY_PREDICTOR = '0;

    localparam stim_row_t DIRECTED [30] = '{
        // fresh after reset, chip time 100
        '{ROW_REQ, MODE_READ,  24'd0,        6'd0,  16'd0, 1'b1, EMPTY_REPORT},
        '{ROW_REQ, MODE_NONE,  24'hFFFFFF,   6'd63, 16'd0, 1'b1, EMPTY_REPORT},
        // zero length mark still gives one chip, short space gives none
        '{ROW_REQ, MODE_PULSE, 24'd0,        6'd0,  16'd0, 1'b1, ONE_CHIP},
        '{ROW_REQ, MODE_PULSE, 24'd49,       6'd0,  16'd0, 1'b1, ONE_CHIP},
        // rounding either side of the half chip
        '{ROW_REQ, MODE_PULSE, 24'd150,      6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_PULSE, 24'd149,      6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_READ,  24'd0,        6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        // longest mark fills the store, then chips are dropped
        '{ROW_REQ, MODE_PULSE, 24'hFFFFFF,   6'd0,  16'd0, 1'b1, FULL_REPORT},
        '{ROW_REQ, MODE_PULSE, 24'd100,      6'd0,  16'd0, 1'b1, FULL_REPORT},
        '{ROW_REQ, MODE_READ,  24'd0,        6'd63, 16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_READ,  24'd0,        6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_NONE,  24'd0,        6'd0,  16'd0, 1'b1, FULL_REPORT},
        '{ROW_REQ, MODE_START, 24'd0,        6'd0,  16'd0, 1'b1, EMPTY_REPORT},
        '{ROW_REQ, MODE_READ,  24'd0,        6'd63, 16'd0, 1'b1, EMPTY_REPORT},
        // mark of exactly the capacity
        '{ROW_REQ, MODE_PULSE, 24'd51200,    6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_START, 24'd0,        6'd0,  16'd0, 1'b1, EMPTY_REPORT},
        // zero chip time: a mark fills the rest with ones
        '{ROW_CFG, MODE_NONE,  24'd0,        6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_PULSE, 24'd5,        6'd0,  16'd0, 1'b1, FULL_REPORT},
        '{ROW_REQ, MODE_READ,  24'd0,        6'd40, 16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_START, 24'd0,        6'd0,  16'd0, 1'b1, EMPTY_REPORT},
        // zero chip time: a space fills the rest with zeros
        '{ROW_CFG, MODE_NONE,  24'd0,        6'd0,  16'd1, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_PULSE, 24'd2,        6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_CFG, MODE_NONE,  24'd0,        6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_PULSE, 24'd7,        6'd0,  16'd0, 1'b1, FULL_REPORT},
        '{ROW_REQ, MODE_READ,  24'd0,        6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        // widest chip time, rounding at the half
        '{ROW_CFG, MODE_NONE,  24'd0,        6'd0,  16'hFFFF, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_START, 24'd0,        6'd0,  16'd0, 1'b1, EMPTY_REPORT},
        '{ROW_REQ, MODE_PULSE, 24'd32767,    6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_PULSE, 24'd32768,    6'd0,  16'd0, 1'b0, BY_PREDICTOR},
        '{ROW_REQ, MODE_READ,  24'd0,        6'd0,  16'd0, 1'b0, BY_PREDICTOR}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             mode;
    logic [DUR_W-1:0]       duration;
    logic [ADDR_IN_W-1:0]   byte_address;
    logic                   chip_time_we;
    logic [CT_W-1:0]        chip_time;
    logic                   done;
    logic [COUNT_W-1:0]     chip_count;
    logic [7:0]             read_data;
    logic                   store_full;

    // shadow copy of the frame state
    logic [7:0]             shadow_bytes [STORE_BYTES_DEF];
    logic [31:0]            shadow_index;
    logic                   shadow_space;
    logic [CT_W-1:0]        shadow_chip_time;

    chip_report_t           chip_reports_due [$];
    int                     mismatch_count;
    int                     burst_left;

    pulse_durations_to_chip_bits dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .duration     (duration),
        .byte_address (byte_address),
        .chip_time_we (chip_time_we),
        .chip_time    (chip_time),
        .done         (done),
        .chip_count   (chip_count),
        .read_data    (read_data),
        .store_full   (store_full)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // expected report for one request, updating the shadow state
    task automatic predict_chip_frame(input mode_t m, input logic [DUR_W-1:0] dur,
                                      input logic [ADDR_IN_W-1:0] addr,
                                      output chip_report_t rep);
        logic [31:0] chips;
        logic [31:0] room;
        logic        mark;
        rep = '0;
        case (m)
            MODE_START:
            begin
                foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
                shadow_index = 0;
                shadow_space = 1'b0;
            end
            MODE_PULSE:
            begin
                mark = !shadow_space;
                if (shadow_chip_time == '0)
                    chips = 32'hFFFF_FFFF;
                else
                    chips = (32'(dur) + 32'(shadow_chip_time >> 1)) / 32'(shadow_chip_time);
                if (mark && chips == 0)
                    chips = 1;
                room = CHIP_CAPACITY - shadow_index;
                if (chips > room)
                    chips = room;
                // chips go in msb first
                repeat (chips)
                begin
                    shadow_bytes[shadow_index >> 3][7 - shadow_index[2:0]] = mark;
                    shadow_index++;
                end
                shadow_space = !shadow_space;
            end
            MODE_READ:
            begin
                rep.data = shadow_bytes[addr];
            end
            default:
            begin
            end
        endcase
        rep.count = shadow_index[COUNT_W-1:0];
        rep.full  = (shadow_index >= CHIP_CAPACITY);
    endtask

    // present one request and hold it until taken
    task automatic issue_request(input mode_t m, input logic [DUR_W-1:0] dur,
                                 input logic [ADDR_IN_W-1:0] addr,
                                 input logic fixed, input chip_report_t want);
        chip_report_t rep;
        start        <= 1'b1;
        mode         <= m;
        duration     <= dur;
        byte_address <= addr;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        predict_chip_frame(m, dur, addr, rep);
        chip_reports_due.push_back(fixed ? want : rep);
    endtask

    // drop start and let every outstanding request report
    task automatic wait_all_reported();
        start <= 1'b0;
        while (chip_reports_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // chip time is only written while the block is idle
    task automatic set_chip_time(input logic [CT_W-1:0] value);
        wait_all_reported();
        chip_time_we <= 1'b1;
        chip_time    <= value;
        @(posedge clk);
        chip_time_we <= 1'b0;
        shadow_chip_time = value;
    endtask

    // sender bursts and gaps, with an occasional full drain
    task automatic pace(input logic gaps_on);
        int gap;
        if ($urandom_range(63) == 0)
        begin
            wait_all_reported();
        end
        else if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 14);
                burst_left = $urandom_range(1, 24);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // pulse lengths clustered around whole chips, with rounding edges and extremes
    function automatic logic [DUR_W-1:0] pick_duration(input logic [CT_W-1:0] ct);
        longint span;
        longint v;
        span = longint'(ct);
        case ($urandom_range(39))
            0:       v = longint'($urandom_range(24'hFFFFFF));
            1:       v = 24'hFFFFFF;
            2, 3:    v = 0;
            4, 5, 6, 7, 8, 9:
                v = (longint'($urandom_range(12)) + 1) * span - span / 2
                    - longint'($urandom_range(1));
            default:
                v = longint'($urandom_range(12)) * span + longint'($urandom_range(ct))
                    - span / 2;
        endcase
        if (v < 0)
            v = 0;
        if (v > 24'hFFFFFF)
            v = 24'hFFFFFF;
        return v[DUR_W-1:0];
    endfunction

    // result checker
    always @(posedge clk)
    begin
        chip_report_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (chip_reports_due.size() == 0)
            begin
                $display("%0t: result with no request outstanding: count %0d data %02h full %0b",
                         $time, chip_count, read_data, store_full);
                mismatch_count++;
            end
            else
            begin
                want = chip_reports_due.pop_front();
                if (chip_count !== want.count)
                begin
                    $display("%0t: chip_count expected %0d actual %0d",
                             $time, want.count, chip_count);
                    mismatch_count++;
                end
                if (read_data !== want.data)
                begin
                    $display("%0t: read_data expected %02h actual %02h",
                             $time, want.data, read_data);
                    mismatch_count++;
                end
                if (store_full !== want.full)
                begin
                    $display("%0t: store_full expected %0b actual %0b",
                             $time, want.full, store_full);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [CT_W-1:0] plan_ct;
        logic            gaps_on;
        int              phase_items;
        int              frame_len;
        int              pick;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        mode         <= MODE_START;
        duration     <= '0;
        byte_address <= '0;
        chip_time_we <= 1'b0;
        chip_time    <= CHIP_TIME_RESET;
        mismatch_count = 0;
        burst_left     = 0;
        foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
        shadow_index     = 0;
        shadow_space     = 1'b0;
        shadow_chip_time = CHIP_TIME_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                set_chip_time(DIRECTED[i].ct);
            else
                issue_request(DIRECTED[i].mode, DIRECTED[i].dur, DIRECTED[i].addr,
                              DIRECTED[i].fixed, DIRECTED[i].want);
        end

        // random frames over several chip times
        for (int ph = 0; ph < CT_PHASES; ph++)
        begin
            case (ph)
                0:       plan_ct = 16'd1;
                1:       plan_ct = 16'hFFFF;
                2:       plan_ct = 16'd0;
                3:       plan_ct = 16'($urandom_range(1, 65535));
                4:       plan_ct = 16'd2;
                5:       plan_ct = CHIP_TIME_RESET;
                6:       plan_ct = 16'($urandom_range(1, 2000));
                default: plan_ct = 16'd7;
            endcase
            set_chip_time(plan_ct);
            gaps_on     = (ph != 5);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / CT_PHASES)
            begin
                if ($urandom_range(9) != 0)
                begin
                    issue_request(MODE_START, 24'($urandom), 6'($urandom), 1'b0, BY_PREDICTOR);
                    phase_items++;
                    pace(gaps_on);
                end
                // keep the phase close to its share of the items
                frame_len = $urandom_range(4, 110);
                if (frame_len > RANDOM_ITEMS / CT_PHASES - phase_items)
                    frame_len = RANDOM_ITEMS / CT_PHASES - phase_items;
                repeat (frame_len)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        issue_request(MODE_PULSE, pick_duration(plan_ct), 6'($urandom),
                                      1'b0, BY_PREDICTOR);
                    else if (pick < 90)
                        issue_request(MODE_READ, 24'($urandom), 6'($urandom),
                                      1'b0, BY_PREDICTOR);
                    else if (pick < 95)
                        issue_request(MODE_NONE, 24'($urandom), 6'($urandom),
                                      1'b0, BY_PREDICTOR);
                    else
                        issue_request(MODE_START, 24'($urandom), 6'($urandom),
                                      1'b0, BY_PREDICTOR);
                    phase_items++;
                    pace(gaps_on);
                end
            end
        end

        // drain and report
        wait_all_reported();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && chip_reports_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
